FILE: rtl/aebd_pkg.sv
// ----------------------------------------------------------------------------
// aebd_pkg
// shared widths, reset values, register indexes and types of the audio energy
// beat detector
// ----------------------------------------------------------------------------
package aebd_pkg;

  localparam int MAX_BLOCK_DEFAULT = 2048;
  localparam int QUEUE_DEPTH       = 2;

  localparam int SAMPLE_W    = 16;
  localparam int ENERGY_W    = 16;
  localparam int WEIGHT_W    = 16;
  localparam int THRESH_W    = 10;
  localparam int HUE_W       = 12;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam int ENERGY_FULL = 32768;

  localparam logic [HUE_W-1:0]    HUE_STEP     = 12'd3;
  localparam logic [HUE_W-1:0]    HUE_WRAP     = 12'd3600;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd6554;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd358;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SMOOTHING_WEIGHT = 8'd0,
    REG_BEAT_THRESHOLD   = 8'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [THRESH_W-1:0] threshold;
  } aebd_cfg_t;

endpackage

FILE: rtl/aebd_if.sv
// ----------------------------------------------------------------------------
// aebd channel interfaces
// sample, result and register write channels with valid/ready handshakes
// ----------------------------------------------------------------------------
interface aebd_sample_if import aebd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface aebd_result_if import aebd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ENERGY_W-1:0] energy;
  logic [ENERGY_W-1:0] average;
  logic                beat;
  logic [HUE_W-1:0]    hue_tenths;

  modport source (output valid, output energy, output average, output beat,
                  output hue_tenths, input ready);
  modport sink   (input valid, input energy, input average, input beat,
                  input hue_tenths, output ready);
endinterface

interface aebd_cfg_if import aebd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/aebd_front.sv
// ----------------------------------------------------------------------------
// aebd_front
// accumulates sample magnitudes and counts, closes a block on last or on a
// full block and hands the block totals to the queue
// ----------------------------------------------------------------------------
module aebd_front import aebd_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEFAULT,
  localparam int CW = $clog2(MAX_BLOCK + 1),
  localparam int SW = SAMPLE_W + CW
) (
  input  logic          clk,
  input  logic          rst,
  aebd_sample_if.sink   samples,
  output logic          push_valid,
  input  logic          push_ready,
  output logic [SW-1:0] push_sum,
  output logic [CW-1:0] push_count
);

  logic [SW-1:0]       sum;
  logic [CW-1:0]       count;
  logic [SAMPLE_W:0]   mag;
  logic [SW-1:0]       sum_next;
  logic [CW-1:0]       count_next;
  logic                close;
  logic                take;

  assign mag = samples.sample[SAMPLE_W-1]
             ? ((SAMPLE_W+1)'(1) << SAMPLE_W) - {1'b0, samples.sample}
             : {1'b0, samples.sample};

  assign sum_next   = sum + SW'(mag);
  assign count_next = count + CW'(1);
  assign close      = samples.last | (count_next == CW'(MAX_BLOCK));

  assign samples.ready = push_ready;
  assign take          = samples.valid & samples.ready;

  assign push_valid = take & close;
  assign push_sum   = sum_next;
  assign push_count = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (take) begin
      if (close) begin
        sum   <= '0;
        count <= '0;
      end else begin
        sum   <= sum_next;
        count <= count_next;
      end
    end
  end

endmodule

FILE: rtl/aebd_queue.sv
// ----------------------------------------------------------------------------
// aebd_queue
// short fifo of closed block totals between the front and back parts
// ----------------------------------------------------------------------------
module aebd_queue import aebd_pkg::*; #(
  parameter int W = 32,
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int NW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         not_full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] pop_data
);

  logic [W-1:0]  mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] fill;

  assign not_full  = fill != NW'(QUEUE_DEPTH);
  assign not_empty = fill != '0;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push & ~pop) begin
        fill <= fill + NW'(1);
      end else if (pop & ~push) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

FILE: rtl/aebd_back.sv
// ----------------------------------------------------------------------------
// aebd_back
// divides block totals to energy, updates the running average, decides the
// beat, advances the hue and holds the result register
// ----------------------------------------------------------------------------
module aebd_back import aebd_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEFAULT,
  localparam int CW  = $clog2(MAX_BLOCK + 1),
  localparam int SW  = SAMPLE_W + CW,
  localparam int SCW = $clog2(SW + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  aebd_cfg_t     cfg,
  input  logic          q_valid,
  input  logic [SW-1:0] q_sum,
  input  logic [CW-1:0] q_count,
  output logic          q_pop,
  aebd_result_if.source results
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_MULA = 7'b0000100,
    S_MULB = 7'b0001000,
    S_AVG  = 7'b0010000,
    S_THR  = 7'b0100000,
    S_CMP  = 7'b1000000
  } state_t;

  state_t                          state;
  logic [SCW-1:0]                  steps;
  logic [CW-1:0]                   rem;
  logic [SW-1:0]                   quo;
  logic [CW-1:0]                   divisor;
  logic [ENERGY_W-1:0]             energy;
  logic [ENERGY_W-1:0]             avg;
  logic [ENERGY_W+WEIGHT_W:0]      prod_a;
  logic [ENERGY_W+WEIGHT_W-1:0]    prod_b;
  logic [ENERGY_W+THRESH_W-1:0]    thr_prod;
  logic [HUE_W-1:0]                hue;
  logic                            out_valid;

  logic [CW:0]                     rem_sh;
  logic                            fits;
  logic [WEIGHT_W:0]               inv_w;
  logic [ENERGY_W+WEIGHT_W+1:0]    blend;
  logic [HUE_W-1:0]                hue_step;
  logic [HUE_W-1:0]                hue_next;
  logic                            beat_now;
  logic                            out_free;

  assign rem_sh   = {rem, quo[SW-1]};
  assign fits     = rem_sh >= {1'b0, divisor};
  assign inv_w    = (WEIGHT_W+1)'(1) << WEIGHT_W;
  assign blend    = {1'b0, prod_a} + {2'b0, prod_b};
  assign hue_step = hue + HUE_STEP;
  assign hue_next = (hue_step >= HUE_WRAP) ? hue_step - HUE_WRAP : hue_step;
  assign beat_now = {2'b0, energy, 8'b0} > thr_prod;
  assign out_free = ~out_valid | results.ready;
  assign q_pop    = (state == S_IDLE) & q_valid;

  assign results.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      steps     <= '0;
      avg       <= '0;
      hue       <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_CMP) & out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            steps <= SCW'(SW);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          steps <= steps - SCW'(1);
          if (steps == SCW'(1)) begin
            state <= S_MULA;
          end
        end
        S_MULA: state <= S_MULB;
        S_MULB: state <= S_AVG;
        S_AVG: begin
          avg   <= blend[ENERGY_W+WEIGHT_W-1:WEIGHT_W];
          state <= S_THR;
        end
        S_THR: state <= S_CMP;
        S_CMP: begin
          if (out_free) begin
            hue   <= hue_next;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        rem     <= '0;
        quo     <= q_sum;
        divisor <= q_count;
      end
      S_DIV: begin
        rem <= fits ? CW'(rem_sh - {1'b0, divisor}) : rem_sh[CW-1:0];
        quo <= {quo[SW-2:0], fits};
      end
      S_MULA: begin
        energy <= quo[ENERGY_W-1:0];
        prod_a <= {{(WEIGHT_W+1){1'b0}}, avg}
                * {{ENERGY_W{1'b0}}, inv_w - {1'b0, cfg.weight}};
      end
      S_MULB: begin
        prod_b <= {{WEIGHT_W{1'b0}}, energy} * {{ENERGY_W{1'b0}}, cfg.weight};
      end
      S_THR: begin
        thr_prod <= {{THRESH_W{1'b0}}, avg} * {{ENERGY_W{1'b0}}, cfg.threshold};
      end
      S_CMP: begin
        if (out_free) begin
          results.energy     <= energy;
          results.average    <= avg;
          results.beat       <= beat_now;
          results.hue_tenths <= hue_next;
        end
      end
      default: ;
    endcase
  end

  ap_energy_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MULA) |-> (quo <= SW'(ENERGY_FULL)))
    else $error("block energy above full scale");

  ap_avg_range: assert property (@(posedge clk) disable iff (rst)
    avg <= ENERGY_W'(ENERGY_FULL))
    else $error("running average above full scale");

  ap_hue_range: assert property (@(posedge clk) disable iff (rst)
    hue < HUE_WRAP)
    else $error("hue out of range");

  ap_pop_starts_div: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == S_DIV))
    else $error("queue pop without division start");

  ap_result_from_cmp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_CMP))
    else $error("result loaded outside compare step");

endmodule

FILE: rtl/audio_energy_beat_detector.sv
// ----------------------------------------------------------------------------
// audio_energy_beat_detector
// block energy, running average, beat flag and hue from an audio sample stream
// ----------------------------------------------------------------------------
//  channel   direction  payload                                  transfer when
//  samples   in         sample[15:0] signed, last                valid & ready
//  results   out        energy, average, beat, hue_tenths        valid & ready
//  cfg       in         index[7:0], data[15:0]                   valid & ready
//
//  samples: one per cycle while the block queue has room
//  each closed block steps the back end through its idle state, the bit-serial
//  divider and the mula, mulb, avg, thr and cmp states
//  a two-entry queue of block totals lets samples flow during that work
//  a stalled result holds in the output register and stalls the back end
//  synchronous reset clears sums, average, hue and loads the register defaults
// ----------------------------------------------------------------------------
module audio_energy_beat_detector import aebd_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  aebd_sample_if.sink   samples,
  aebd_result_if.source results,
  aebd_cfg_if.sink      cfg
);

  localparam int CW = $clog2(MAX_BLOCK + 1);
  localparam int SW = SAMPLE_W + CW;

  aebd_cfg_t        cfg_regs;
  logic             push_valid;
  logic             push_ready;
  logic [SW-1:0]    push_sum;
  logic [CW-1:0]    push_count;
  logic             q_valid;
  logic             q_pop;
  logic [SW+CW-1:0] q_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.weight    <= WEIGHT_RESET;
      cfg_regs.threshold <= THRESH_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SMOOTHING_WEIGHT: cfg_regs.weight    <= cfg.data[WEIGHT_W-1:0];
        REG_BEAT_THRESHOLD:   cfg_regs.threshold <= cfg.data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  aebd_front #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_sum   (push_sum),
    .push_count (push_count)
  );

  aebd_queue #(
    .W (SW + CW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_data ({push_sum, push_count}),
    .not_full  (push_ready),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  aebd_back #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .q_valid (q_valid),
    .q_sum   (q_data[SW+CW-1:CW]),
    .q_count (q_data[CW-1:0]),
    .q_pop   (q_pop),
    .results (results)
  );

endmodule
